// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define HDTI_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");
`define HDTI_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define HDTI_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define HDTI_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- hdl/hdti_pkg.sv -----
package hdti_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int VF           = 15;
  localparam int CORDIC_STEPS = 28;
  localparam int WORK_FRAC    = 30;

  localparam int UNIT_W  = VF + 2;
  localparam int SC_XW   = WORK_FRAC + 4;
  localparam int SC_ZW   = 33;
  localparam int VEC_W   = 24;
  localparam int PROD_W  = 2 * VEC_W;
  localparam int AT_XW   = VEC_W + WORK_FRAC - VF + 3;
  localparam int AT_ZW   = 34;
  localparam int SQ_NW   = 2 * VF + 1;
  localparam int SQ_RW   = 2 * VF + 2;
  localparam int SQ_STEPS = VF + 1;

  localparam logic [31:0] CORDIC_GAIN = 32'd652032874;
  localparam logic [31:0] PHASE_QUARTER = 32'h4000_0000;
  localparam logic [31:0] PHASE_HALF    = 32'h8000_0000;

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005
  };

  localparam logic signed [PROD_W-1:0] VROUND = PROD_W'(1) << (VF - 1);

  // Q8.VF product, rounded half up
  function automatic logic signed [VEC_W-1:0] vmul(input logic signed [VEC_W-1:0] a,
                                                   input logic signed [VEC_W-1:0] b);
    logic signed [PROD_W-1:0] p;
    p = a * b + VROUND;
    return VEC_W'(p >>> VF);
  endfunction

endpackage

// ----- hdl/hdti_sincos.sv -----
module hdti_sincos (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic [31:0]                           phase_i,
  output logic signed [hdti_pkg::UNIT_W-1:0]    cos_o,
  output logic signed [hdti_pkg::UNIT_W-1:0]    sin_o
);
  localparam int XW = hdti_pkg::SC_XW;
  localparam int ZW = hdti_pkg::SC_ZW;
  localparam int N  = hdti_pkg::CORDIC_STEPS;
  localparam int UW = hdti_pkg::UNIT_W;
  localparam int SH = hdti_pkg::WORK_FRAC - hdti_pkg::VF;

  localparam logic signed [XW-1:0] ONE_X = XW'(1) << hdti_pkg::VF;
  localparam logic signed [XW-1:0] RND_X = XW'(1) << (SH - 1);

  logic signed [XW-1:0] x_q [N];
  logic signed [XW-1:0] y_q [N];
  logic signed [ZW-1:0] z_q [N];
  logic [1:0]           quad_q [N];

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [XW-1:0] xa, ya;
    logic signed [ZW-1:0] za, at;
    logic [1:0]           qa;
    if (i == 0) begin : g_first
      assign xa = XW'($signed({1'b0, hdti_pkg::CORDIC_GAIN}));
      assign ya = '0;
      assign za = ZW'($signed({1'b0, phase_i[29:0]}));
      assign qa = phase_i[31:30];
    end else begin : g_rest
      assign xa = x_q[i-1];
      assign ya = y_q[i-1];
      assign za = z_q[i-1];
      assign qa = quad_q[i-1];
    end
    assign at = ZW'($signed({1'b0, hdti_pkg::ATAN_TAB[i]}));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (za >= 0) begin
          x_q[i] <= xa - (ya >>> i);
          y_q[i] <= ya + (xa >>> i);
          z_q[i] <= za - at;
        end else begin
          x_q[i] <= xa + (ya >>> i);
          y_q[i] <= ya - (xa >>> i);
          z_q[i] <= za + at;
        end
        quad_q[i] <= qa;
      end
    end
  end

  logic signed [XW-1:0] xr, yr;
  logic signed [UW-1:0] xc, yc, cos_d, sin_d;

  always_comb begin
    xr = (x_q[N-1] + RND_X) >>> SH;
    yr = (y_q[N-1] + RND_X) >>> SH;
    if (xr > ONE_X) xc = UW'(ONE_X);
    else if (xr < -ONE_X) xc = UW'(-ONE_X);
    else xc = UW'(xr);
    if (yr > ONE_X) yc = UW'(ONE_X);
    else if (yr < -ONE_X) yc = UW'(-ONE_X);
    else yc = UW'(yr);
    case (quad_q[N-1])
      2'd0:    begin cos_d = xc;  sin_d = yc;  end
      2'd1:    begin cos_d = -yc; sin_d = xc;  end
      2'd2:    begin cos_d = -xc; sin_d = -yc; end
      default: begin cos_d = yc;  sin_d = -xc; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_o <= cos_d;
      sin_o <= sin_d;
    end
  end
endmodule

// ----- hdl/hdti_vec.sv -----
module hdti_vec (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [hdti_pkg::UNIT_W-1:0]   ch_i,
  input  logic signed [hdti_pkg::UNIT_W-1:0]   sh_i,
  input  logic signed [hdti_pkg::UNIT_W-1:0]   cph_i,
  input  logic signed [hdti_pkg::UNIT_W-1:0]   sph_i,
  input  logic signed [hdti_pkg::UNIT_W-1:0]   cd_i,
  input  logic signed [hdti_pkg::UNIT_W-1:0]   sd_i,
  input  logic signed [hdti_pkg::UNIT_W-1:0]   cpd_i,
  input  logic signed [hdti_pkg::UNIT_W-1:0]   spd_i,
  output logic signed [hdti_pkg::VEC_W-1:0]    ix_o,
  output logic signed [hdti_pkg::VEC_W-1:0]    iy_o,
  output logic signed [hdti_pkg::VEC_W-1:0]    iz_o,
  output logic signed [hdti_pkg::VEC_W-1:0]    ox_o,
  output logic signed [hdti_pkg::VEC_W-1:0]    oy_o,
  output logic signed [hdti_pkg::VEC_W-1:0]    oz_o
);
  localparam int W = hdti_pkg::VEC_W;

  logic signed [W-1:0] ch, sh, cph, sph, cd, sd, cpd, spd;
  assign ch  = W'(ch_i);
  assign sh  = W'(sh_i);
  assign cph = W'(cph_i);
  assign sph = W'(sph_i);
  assign cd  = W'(cd_i);
  assign sd  = W'(sd_i);
  assign cpd = W'(cpd_i);
  assign spd = W'(spd_i);

  // stage 1: half and difference vectors
  logic signed [W-1:0] hx1_q, hy1_q, hz1_q, dx1_q, dy1_q, dz1_q, ch1_q, sh1_q, cph1_q, sph1_q;
  // stage 2: tilt about y
  logic signed [W-1:0] tx2_q, tz2_q, dy2_q, cph2_q, sph2_q, hx2_q, hy2_q, hz2_q;
  // stage 3: turn about z
  logic signed [W-1:0] ix3_q, iy3_q, iz3_q, hx3_q, hy3_q, hz3_q;
  // stage 4: dot product
  logic signed [W-1:0] dot4_q, ix4_q, iy4_q, iz4_q, hx4_q, hy4_q, hz4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hx1_q  <= hdti_pkg::vmul(sh, cph);
      hy1_q  <= hdti_pkg::vmul(sh, sph);
      hz1_q  <= ch;
      dx1_q  <= hdti_pkg::vmul(sd, cpd);
      dy1_q  <= hdti_pkg::vmul(sd, spd);
      dz1_q  <= cd;
      ch1_q  <= ch;
      sh1_q  <= sh;
      cph1_q <= cph;
      sph1_q <= sph;

      tx2_q  <= hdti_pkg::vmul(dx1_q, ch1_q) + hdti_pkg::vmul(dz1_q, sh1_q);
      tz2_q  <= hdti_pkg::vmul(dz1_q, ch1_q) - hdti_pkg::vmul(dx1_q, sh1_q);
      dy2_q  <= dy1_q;
      cph2_q <= cph1_q;
      sph2_q <= sph1_q;
      hx2_q  <= hx1_q;
      hy2_q  <= hy1_q;
      hz2_q  <= hz1_q;

      ix3_q <= hdti_pkg::vmul(tx2_q, cph2_q) - hdti_pkg::vmul(dy2_q, sph2_q);
      iy3_q <= hdti_pkg::vmul(tx2_q, sph2_q) + hdti_pkg::vmul(dy2_q, cph2_q);
      iz3_q <= tz2_q;
      hx3_q <= hx2_q;
      hy3_q <= hy2_q;
      hz3_q <= hz2_q;

      dot4_q <= hdti_pkg::vmul(ix3_q, hx3_q) + hdti_pkg::vmul(iy3_q, hy3_q)
              + hdti_pkg::vmul(iz3_q, hz3_q);
      ix4_q <= ix3_q;
      iy4_q <= iy3_q;
      iz4_q <= iz3_q;
      hx4_q <= hx3_q;
      hy4_q <= hy3_q;
      hz4_q <= hz3_q;

      // mirror about the half vector
      ox_o <= (hdti_pkg::vmul(dot4_q, hx4_q) <<< 1) - ix4_q;
      oy_o <= (hdti_pkg::vmul(dot4_q, hy4_q) <<< 1) - iy4_q;
      oz_o <= (hdti_pkg::vmul(dot4_q, hz4_q) <<< 1) - iz4_q;
      ix_o <= ix4_q;
      iy_o <= iy4_q;
      iz_o <= iz4_q;
    end
  end
endmodule

// ----- hdl/hdti_isqrt.sv -----
module hdti_isqrt (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic [hdti_pkg::SQ_NW-1:0]           n_i,
  input  logic signed [hdti_pkg::UNIT_W-1:0]   side_i,
  output logic [hdti_pkg::VF:0]                root_o,
  output logic signed [hdti_pkg::UNIT_W-1:0]   side_o
);
  localparam int NW = hdti_pkg::SQ_NW;
  localparam int RW = hdti_pkg::SQ_RW;
  localparam int N  = hdti_pkg::SQ_STEPS;
  localparam int UW = hdti_pkg::UNIT_W;

  logic [NW-1:0]        n_q [N];
  logic [RW-1:0]        r_q [N];
  logic signed [UW-1:0] side_q [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [RW-1:0] BIT = RW'(1) << (2 * (N - 1 - k));
    logic [NW-1:0]        na;
    logic [RW-1:0]        ra, trial;
    logic signed [UW-1:0] sa;
    if (k == 0) begin : g_first
      assign na = n_i;
      assign ra = '0;
      assign sa = side_i;
    end else begin : g_rest
      assign na = n_q[k-1];
      assign ra = r_q[k-1];
      assign sa = side_q[k-1];
    end
    assign trial = ra + BIT;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (RW'(na) >= trial) begin
          n_q[k] <= NW'(RW'(na) - trial);
          r_q[k] <= (ra >> 1) + BIT;
        end else begin
          n_q[k] <= na;
          r_q[k] <= ra >> 1;
        end
        side_q[k] <= sa;
      end
    end
  end

  assign root_o = r_q[N-1][hdti_pkg::VF:0];
  assign side_o = side_q[N-1];
endmodule

// ----- hdl/hdti_atan2.sv -----
module hdti_atan2 (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [hdti_pkg::VEC_W-1:0]    y_i,
  input  logic signed [hdti_pkg::VEC_W-1:0]    x_i,
  output logic signed [hdti_pkg::AT_ZW-1:0]    phase_o
);
  localparam int XW = hdti_pkg::AT_XW;
  localparam int ZW = hdti_pkg::AT_ZW;
  localparam int N  = hdti_pkg::CORDIC_STEPS;
  localparam int SH = hdti_pkg::WORK_FRAC - hdti_pkg::VF;
  localparam logic signed [ZW-1:0] QUARTER = ZW'($signed({1'b0, hdti_pkg::PHASE_QUARTER}));

  logic signed [XW-1:0] xp_q, yp_q, xs, ys;
  logic signed [ZW-1:0] zp_q;
  logic                 zero_p_q;
  logic signed [XW-1:0] x_q [N];
  logic signed [XW-1:0] y_q [N];
  logic signed [ZW-1:0] z_q [N];
  logic                 zero_q [N];

  assign xs = XW'(x_i) <<< SH;
  assign ys = XW'(y_i) <<< SH;

  // quarter-turn pre-rotation into the right half plane
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_p_q <= (x_i == '0) && (y_i == '0);
      if (xs < 0) begin
        if (ys >= 0) begin
          xp_q <= ys;  yp_q <= -xs; zp_q <= QUARTER;
        end else begin
          xp_q <= -ys; yp_q <= xs;  zp_q <= -QUARTER;
        end
      end else begin
        xp_q <= xs; yp_q <= ys; zp_q <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [XW-1:0] xa, ya;
    logic signed [ZW-1:0] za, at;
    logic                 zr;
    if (i == 0) begin : g_first
      assign xa = xp_q;
      assign ya = yp_q;
      assign za = zp_q;
      assign zr = zero_p_q;
    end else begin : g_rest
      assign xa = x_q[i-1];
      assign ya = y_q[i-1];
      assign za = z_q[i-1];
      assign zr = zero_q[i-1];
    end
    assign at = ZW'($signed({1'b0, hdti_pkg::ATAN_TAB[i]}));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (ya >= 0) begin
          x_q[i] <= xa + (ya >>> i);
          y_q[i] <= ya - (xa >>> i);
          z_q[i] <= za + at;
        end else begin
          x_q[i] <= xa - (ya >>> i);
          y_q[i] <= ya + (xa >>> i);
          z_q[i] <= za - at;
        end
        zero_q[i] <= zr;
      end
    end
  end

  assign phase_o = zero_q[N-1] ? '0 : z_q[N-1];
endmodule

// ----- hdl/half_diff_to_in_out_angles_unit.sv -----
// channel | valid       | stall       | payload
// in      | in_valid_i  | in_stall_o  | half_polar_i, half_azimuth_i, diff_polar_i,
//         |             |             | diff_azimuth_i
// out     | out_valid_o | out_stall_i | incoming_polar_o, incoming_azimuth_o,
//         |             |             | outgoing_polar_o, outgoing_azimuth_o,
//         |             |             | both_upper_hemisphere_o
//
// One beat enters per cycle while in_stall_o is low.
// A beat passes through the chain: 29-stage sine/cosine CORDIC, 5 vector stages,
// 17 stages of square root, 29-stage vectoring CORDIC and the output register.
// Reset clears only the valid bits; the data path carries no reset.
// The whole pipeline holds while a result waits under out_stall_i; empty
// output slots never hold it back.
`include "assert_macros.svh"

module half_diff_to_in_out_angles_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [14:0] half_polar_i,
  input  logic [15:0] half_azimuth_i,
  input  logic [14:0] diff_polar_i,
  input  logic [15:0] diff_azimuth_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] incoming_polar_o,
  output logic [15:0] incoming_azimuth_o,
  output logic [15:0] outgoing_polar_o,
  output logic [15:0] outgoing_azimuth_o,
  output logic        both_upper_hemisphere_o
);
  localparam int AB  = hdti_pkg::ANGLE_BITS;
  localparam int UW  = hdti_pkg::UNIT_W;
  localparam int VW  = hdti_pkg::VEC_W;
  localparam int ZW  = hdti_pkg::AT_ZW;
  localparam int NW  = hdti_pkg::SQ_NW;
  localparam int DLY = hdti_pkg::SQ_STEPS + 1;
  localparam int LAT = (hdti_pkg::CORDIC_STEPS + 1) * 2 + 5 + DLY + 1;

  localparam logic signed [UW-1:0] ONE = UW'(1) << hdti_pkg::VF;
  localparam logic [NW-1:0] ONE_SQ = NW'(1) << (2 * hdti_pkg::VF);
  localparam logic signed [ZW-1:0] HALF_Z = ZW'($signed({1'b0, hdti_pkg::PHASE_HALF}));
  localparam logic [31:0] PH_RND = 32'd1 << (31 - AB);
  localparam logic [AB-1:0] QUARTER_A = AB'(1) << (AB - 2);

  logic adv;
  logic [LAT-1:0] valid_q;

  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;
  assign out_valid_o = valid_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[LAT-2:0], in_valid_i};
    end
  end

  // sine and cosine of the four input angles
  logic signed [UW-1:0] ch, sh, cph, sph, cd, sd, cpd, spd;

  hdti_sincos u_sc_hp (.clk_i, .en_i(adv), .phase_i({1'b0, half_polar_i, 16'd0}),
                       .cos_o(ch), .sin_o(sh));
  hdti_sincos u_sc_ha (.clk_i, .en_i(adv), .phase_i({half_azimuth_i, 16'd0}),
                       .cos_o(cph), .sin_o(sph));
  hdti_sincos u_sc_dp (.clk_i, .en_i(adv), .phase_i({1'b0, diff_polar_i, 16'd0}),
                       .cos_o(cd), .sin_o(sd));
  hdti_sincos u_sc_da (.clk_i, .en_i(adv), .phase_i({diff_azimuth_i, 16'd0}),
                       .cos_o(cpd), .sin_o(spd));

  logic signed [VW-1:0] ix, iy, iz, ox, oy, oz;

  hdti_vec u_vec (
    .clk_i, .en_i(adv),
    .ch_i(ch), .sh_i(sh), .cph_i(cph), .sph_i(sph),
    .cd_i(cd), .sd_i(sd), .cpd_i(cpd), .spd_i(spd),
    .ix_o(ix), .iy_o(iy), .iz_o(iz), .ox_o(ox), .oy_o(oy), .oz_o(oz)
  );

  // polar path: clamp z, form 1 - z*z
  logic signed [UW-1:0] izc, ozc, izz_q, ozz_q, izs, ozs;
  logic [NW-1:0]        in_q, on_q;
  logic [hdti_pkg::VF:0] iroot, oroot;

  assign izc = (iz > VW'(ONE)) ? ONE : ((iz < -VW'(ONE)) ? -ONE : UW'(iz));
  assign ozc = (oz > VW'(ONE)) ? ONE : ((oz < -VW'(ONE)) ? -ONE : UW'(oz));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      izz_q <= izc;
      ozz_q <= ozc;
      in_q  <= ONE_SQ - (NW'(izc) * NW'(izc));
      on_q  <= ONE_SQ - (NW'(ozc) * NW'(ozc));
    end
  end

  hdti_isqrt u_sq_i (.clk_i, .en_i(adv), .n_i(in_q), .side_i(izz_q),
                     .root_o(iroot), .side_o(izs));
  hdti_isqrt u_sq_o (.clk_i, .en_i(adv), .n_i(on_q), .side_i(ozz_q),
                     .root_o(oroot), .side_o(ozs));

  // azimuth path: align x and y with the square root
  logic signed [VW-1:0] ix_q [DLY];
  logic signed [VW-1:0] iy_q [DLY];
  logic signed [VW-1:0] ox_q [DLY];
  logic signed [VW-1:0] oy_q [DLY];

  for (genvar k = 0; k < DLY; k++) begin : g_dly
    if (k == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (adv) begin
          ix_q[k] <= ix; iy_q[k] <= iy; ox_q[k] <= ox; oy_q[k] <= oy;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk_i) begin
        if (adv) begin
          ix_q[k] <= ix_q[k-1]; iy_q[k] <= iy_q[k-1];
          ox_q[k] <= ox_q[k-1]; oy_q[k] <= oy_q[k-1];
        end
      end
    end
  end

  logic signed [ZW-1:0] ip_z, op_z, ia_z, oa_z;

  hdti_atan2 u_at_ip (.clk_i, .en_i(adv), .y_i(VW'(signed'({1'b0, iroot}))),
                      .x_i(VW'(izs)), .phase_o(ip_z));
  hdti_atan2 u_at_op (.clk_i, .en_i(adv), .y_i(VW'(signed'({1'b0, oroot}))),
                      .x_i(VW'(ozs)), .phase_o(op_z));
  hdti_atan2 u_at_ia (.clk_i, .en_i(adv), .y_i(iy_q[DLY-1]), .x_i(ix_q[DLY-1]),
                      .phase_o(ia_z));
  hdti_atan2 u_at_oa (.clk_i, .en_i(adv), .y_i(oy_q[DLY-1]), .x_i(ox_q[DLY-1]),
                      .phase_o(oa_z));

  logic [31:0] ip_p, op_p, ip_r, op_r, ia_r, oa_r;

  always_comb begin
    ip_p = (ip_z < 0) ? 32'd0 : ((ip_z > HALF_Z) ? hdti_pkg::PHASE_HALF : ip_z[31:0]);
    op_p = (op_z < 0) ? 32'd0 : ((op_z > HALF_Z) ? hdti_pkg::PHASE_HALF : op_z[31:0]);
    ip_r = ip_p + PH_RND;
    op_r = op_p + PH_RND;
    ia_r = ia_z[31:0] + PH_RND;
    oa_r = oa_z[31:0] + PH_RND;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      incoming_polar_o   <= ip_r[31:32-AB];
      outgoing_polar_o   <= op_r[31:32-AB];
      incoming_azimuth_o <= ia_r[31:32-AB];
      outgoing_azimuth_o <= oa_r[31:32-AB];
      both_upper_hemisphere_o <= (ip_r[31:32-AB] <= QUARTER_A) &&
                                 (op_r[31:32-AB] <= QUARTER_A);
    end
  end

  `HDTI_ASSERT_IMP(a_hemi_flag, clk_i, rst_ni, out_valid_o, both_upper_hemisphere_o == ((incoming_polar_o <= QUARTER_A) && (outgoing_polar_o <= QUARTER_A)))
  `HDTI_ASSERT_IMP(a_polar_range, clk_i, rst_ni, out_valid_o, (incoming_polar_o <= (QUARTER_A << 1)) && (outgoing_polar_o <= (QUARTER_A << 1)))
  `HDTI_ASSERT_NXT(a_hold_result, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(incoming_azimuth_o) && $stable(outgoing_azimuth_o))
endmodule

// ----- dv/half_diff_to_in_out_angles_unit_test.sv -----
module half_diff_to_in_out_angles_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 120;
  localparam longint ONE        = 64'sd32768;

  typedef struct packed {
    logic [15:0] in_polar;
    logic [15:0] in_azimuth;
    logic [15:0] out_polar;
    logic [15:0] out_azimuth;
    logic        both_upper;
  } angles_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [14:0] half_polar_i = '0;
  logic [15:0] half_azimuth_i = '0;
  logic [14:0] diff_polar_i = '0;
  logic [15:0] diff_azimuth_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] incoming_polar_o;
  logic [15:0] incoming_azimuth_o;
  logic [15:0] outgoing_polar_o;
  logic [15:0] outgoing_azimuth_o;
  logic        both_upper_hemisphere_o;

  angles_t expected_angles[$];
  int      mismatches = 0;
  int      idle_cycles = 0;
  bit      no_idling = 1'b0;
  int      stall_left = 0;

  half_diff_to_in_out_angles_unit u_dut (.*);

  always #2 clk_i = ~clk_i;

  function automatic longint round_shr(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint qmul(longint a, longint b);
    return round_shr(a * b, 15);
  endfunction

  function automatic void rotate_unit(input logic [31:0] ph, output longint c,
                                      output longint s);
    longint x, y, z, dx, dy;
    x = longint'(hdti_pkg::CORDIC_GAIN);
    y = 0;
    z = longint'(ph[29:0]);
    for (int i = 0; i < 28; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(hdti_pkg::ATAN_TAB[i]);
      end else begin
        x += dx; y -= dy; z += longint'(hdti_pkg::ATAN_TAB[i]);
      end
    end
    x = clamp(round_shr(x, 15), -ONE, ONE);
    y = clamp(round_shr(y, 15), -ONE, ONE);
    case (ph[31:30])
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic longint vector_phase(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    x = x * 32768;
    y = y * 32768;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 64'sd1073741824;
      end else begin
        t = x; x = -y; y = t; z = -64'sd1073741824;
      end
    end
    for (int i = 0; i < 28; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(hdti_pkg::ATAN_TAB[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(hdti_pkg::ATAN_TAB[i]);
      end
    end
    return z;
  endfunction

  function automatic longint floor_sqrt(longint n);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] to_angle(logic [63:0] p);
    logic [63:0] r;
    r = (p + 64'h8000) >> 16;
    return r[15:0];
  endfunction

  function automatic logic [15:0] polar_angle(longint zc);
    longint zz, s;
    zz = clamp(zc, -ONE, ONE);
    s = floor_sqrt(ONE * ONE - zz * zz);
    return to_angle(clamp(vector_phase(s, zz), 0, 64'sd2147483648));
  endfunction

  function automatic logic [15:0] azimuth_angle(longint y, longint x);
    return to_angle(vector_phase(y, x) & 64'hFFFF_FFFF);
  endfunction

  function automatic angles_t mirror_angles(logic [14:0] hp, logic [15:0] ha,
                                            logic [14:0] dp, logic [15:0] da);
    longint ch, sh, cph, sph, cd, sd, cpd, spd;
    longint hx, hy, hz, dx, dy, dz, tx, tz, ix, iy, iz, dot, ox, oy, oz;
    angles_t a;
    rotate_unit({1'b0, hp, 16'h0}, ch, sh);
    rotate_unit({ha, 16'h0}, cph, sph);
    rotate_unit({1'b0, dp, 16'h0}, cd, sd);
    rotate_unit({da, 16'h0}, cpd, spd);
    hx = qmul(sh, cph); hy = qmul(sh, sph); hz = ch;
    dx = qmul(sd, cpd); dy = qmul(sd, spd); dz = cd;
    tx = qmul(dx, ch) + qmul(dz, sh);
    tz = qmul(dz, ch) - qmul(dx, sh);
    ix = qmul(tx, cph) - qmul(dy, sph);
    iy = qmul(tx, sph) + qmul(dy, cph);
    iz = tz;
    dot = qmul(ix, hx) + qmul(iy, hy) + qmul(iz, hz);
    ox = 2 * qmul(dot, hx) - ix;
    oy = 2 * qmul(dot, hy) - iy;
    oz = 2 * qmul(dot, hz) - iz;
    a.in_polar    = polar_angle(iz);
    a.in_azimuth  = azimuth_angle(iy, ix);
    a.out_polar   = polar_angle(oz);
    a.out_azimuth = azimuth_angle(oy, ox);
    a.both_upper  = (a.in_polar <= 16'd16384) && (a.out_polar <= 16'd16384);
    return a;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idling || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // predict on every accepted input beat
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      expected_angles.push_back(mirror_angles(half_polar_i, half_azimuth_i,
                                              diff_polar_i, diff_azimuth_i));
  end

  always @(posedge clk_i) begin
    angles_t want, got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{incoming_polar_o, incoming_azimuth_o, outgoing_polar_o,
              outgoing_azimuth_o, both_upper_hemisphere_o};
      if (expected_angles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = expected_angles.pop_front();
        if (want !== got) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp ip=%0d ia=%0d op=%0d oa=%0d up=%0b  got ip=%0d ia=%0d op=%0d oa=%0d up=%0b",
                     want.in_polar, want.in_azimuth, want.out_polar, want.out_azimuth,
                     want.both_upper, got.in_polar, got.in_azimuth, got.out_polar,
                     got.out_azimuth, got.both_upper);
        end
      end
    end
  end

  // hold stall for random stretches
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= pick_gap();
      out_stall_i <= !no_idling && ($urandom_range(0, 1) == 1);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (rst_ni && idle_cycles >= WATCHDOG_LIMIT) begin
      $display("half_diff_to_in_out_angles_unit_test: errors");
      $finish;
    end
  end

  task automatic send_beat(logic [14:0] hp, logic [15:0] ha, logic [14:0] dp,
                           logic [15:0] da);
    int gap;
    in_valid_i <= 1'b1;
    half_polar_i <= hp;
    half_azimuth_i <= ha;
    diff_polar_i <= dp;
    diff_azimuth_i <= da;
    do @(posedge clk_i); while (in_stall_o);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic test_extremes();
    logic [14:0] polars[4] = '{15'd0, 15'd16384, 15'd8192, 15'h7FFF};
    logic [15:0] azis[4] = '{16'd0, 16'hFFFF, 16'd16384, 16'd32768};
    // straight up in and out: zero vector for both azimuths
    send_beat(15'd0, 16'd0, 15'd0, 16'd0);
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        send_beat(polars[i], azis[j], polars[3 - i], azis[(j + i) % 4]);
    // grazing and out-of-range polar angles push acos to its clamps
    send_beat(15'd16384, 16'd0, 15'd16384, 16'd0);
    send_beat(15'd16384, 16'd32768, 15'd16384, 16'd32768);
    send_beat(15'h7FFF, 16'hFFFF, 15'h7FFF, 16'hFFFF);
    send_beat(15'd1, 16'd1, 15'd1, 16'hFFFF);
  endtask

  task automatic send_random(int count);
    logic [14:0] hp, dp;
    for (int n = 0; n < count; n++) begin
      hp = ($urandom_range(0, 9) == 0) ? 15'($urandom) : 15'($urandom_range(0, 16384));
      dp = ($urandom_range(0, 9) == 0) ? 15'($urandom) : 15'($urandom_range(0, 16384));
      send_beat(hp, 16'($urandom), dp, 16'($urandom));
    end
  endtask

  task automatic test_back_to_back();
    no_idling = 1'b1;
    send_random(300);
    no_idling = 1'b0;
  endtask

  task automatic test_random_gaps();
    send_random(1100);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_back_to_back();
    test_random_gaps();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_angles.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_angles.size() == 0)
      $display("half_diff_to_in_out_angles_unit_test: clean");
    else
      $display("half_diff_to_in_out_angles_unit_test: errors");
    $finish;
  end

endmodule
